/* design/lurt_pkg.sv */
// ----------------------------------------------------------------------------
// lurt_pkg
// Shared constants and types of the longest unique run tracker.
// ----------------------------------------------------------------------------
package lurt_pkg;

   localparam longint unsigned MAX_LEN  = 65536;
   localparam int              ALPHABET = 256;

   localparam int BYTE_W = 8;
   localparam int ADDR_W = $clog2(ALPHABET);
   localparam int POS_W  = $clog2(MAX_LEN);
   localparam int LEN_W  = $clog2(MAX_LEN + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [LEN_W-1:0]  len_type;

endpackage

/* design/lurt_ram.sv */
// ----------------------------------------------------------------------------
// lurt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lurt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/longest_unique_run_tracker.sv */
// ----------------------------------------------------------------------------
// longest_unique_run_tracker
// Streams bytes, one item per byte, and reports for every byte the length of
// the repeat-free window ending there and the best such length in the current
// string. Throughput is one item per clock while rsp_stall is low: the
// last-seen position of each byte value sits in a 256 x 16 RAM that is read
// when the item is accepted and written back when it leaves the read stage,
// and a one-entry forwarding register covers a read that overlaps the write of
// the item just before it. Seen marks are flip-flops, cleared by reset and by
// the closing byte of a string (req_end_of_string), so no clearing pass is
// needed. A result reaches the rsp_ ports through the read stage and then the
// result register. A result waiting under rsp_stall does not block the input:
// one more item is taken and parked with its RAM read done. Bytes beyond
// MAX_LEN in one string are not counted; their result carries rsp_overflow and
// repeats the last window length.
// ----------------------------------------------------------------------------
module longest_unique_run_tracker
   import lurt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              req_end_of_string,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LEN_W-1:0]  rsp_window_length,
   output logic [LEN_W-1:0]  rsp_best_length,
   output logic              rsp_overflow,
   output logic              rsp_string_done
);

   // Read stage: item whose table read is in flight or parked.
   logic     p1_valid_ff;
   addr_type p1_addr_ff;
   logic     p1_eos_ff;

   // Per-string state.
   logic [ALPHABET-1:0] seen_ff;
   pos_type             start_ff;
   len_type             pos_ff;
   len_type             best_ff;

   // Most recent table write, for read-during-write forwarding.
   logic     fwd_valid_ff;
   addr_type fwd_addr_ff;
   pos_type  fwd_pos_ff;

   // Result register.
   logic    rsp_valid_ff;
   len_type rsp_window_ff;
   len_type rsp_best_ff;
   logic    rsp_ovf_ff;
   logic    rsp_done_ff;

   logic     advance;
   logic     fire;
   logic     req_accept;
   addr_type req_addr;
   pos_type  ram_rdata;
   pos_type  last_pos;
   logic     ovf;
   logic     hit;
   pos_type  start_in;
   len_type  win_in;
   len_type  best_in;
   logic     wr_en;

   // The result register frees up when empty or when its item is taken.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = p1_valid_ff && advance;
   assign req_stall  = p1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Fold the byte into the table.
   assign req_addr = addr_type'(req_byte_value % ALPHABET);

   lurt_ram #(
      .WIDTH (POS_W),
      .DEPTH (ALPHABET)
   ) u_last_pos (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p1_addr_ff),
      .wr_data (pos_ff[POS_W-1:0]),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rdata)
   );

   // Update step: a string at MAX_LEN leaves all state alone, but its closing byte still clears it.
   always_comb begin
      ovf      = (pos_ff >= len_type'(MAX_LEN));
      // Take the write that the RAM read may have missed.
      last_pos = (fwd_valid_ff && (fwd_addr_ff == p1_addr_ff)) ? fwd_pos_ff : ram_rdata;
      // Only a byte seen inside the current window moves the start.
      hit      = seen_ff[p1_addr_ff] && (last_pos >= start_ff);
      start_in = hit ? pos_type'(last_pos + pos_type'(1)) : start_ff;
      if (ovf) begin
         win_in = pos_ff - len_type'(start_ff);
      end else begin
         win_in = pos_ff + len_type'(1) - len_type'(start_in);
      end
      best_in  = (!ovf && (win_in > best_ff)) ? win_in : best_ff;
      wr_en    = fire && !ovf;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         seen_ff      <= '0;
         start_ff     <= '0;
         pos_ff       <= '0;
         best_ff      <= '0;
      end else begin
         // Hold the parked item until the result register takes it.
         if (req_accept) begin
            p1_valid_ff <= 1'b1;
         end else if (advance) begin
            p1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= p1_valid_ff;
         end
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
         if (fire) begin
            // Closing byte: drop the whole string state.
            if (p1_eos_ff) begin
               seen_ff  <= '0;
               start_ff <= '0;
               pos_ff   <= '0;
               best_ff  <= '0;
            end else if (!ovf) begin
               seen_ff[p1_addr_ff] <= 1'b1;
               start_ff            <= start_in;
               pos_ff              <= pos_ff + len_type'(1);
               best_ff             <= best_in;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_addr_ff <= req_addr;
         p1_eos_ff  <= req_end_of_string;
      end
      if (wr_en) begin
         fwd_addr_ff <= p1_addr_ff;
         fwd_pos_ff  <= pos_ff[POS_W-1:0];
      end
      if (fire) begin
         rsp_window_ff <= win_in;
         rsp_best_ff   <= best_in;
         rsp_ovf_ff    <= ovf;
         rsp_done_ff   <= p1_eos_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_window_length = rsp_window_ff;
   assign rsp_best_length   = rsp_best_ff;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_string_done   = rsp_done_ff;

endmodule

/* design/lurt_checker.sv */
// ----------------------------------------------------------------------------
// lurt_checker
// Port-level assertions for the longest unique run tracker.
// ----------------------------------------------------------------------------
module lurt_checker
   import lurt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [BYTE_W-1:0] req_byte_value,
   input logic              req_end_of_string,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [LEN_W-1:0]  rsp_window_length,
   input logic [LEN_W-1:0]  rsp_best_length,
   input logic              rsp_overflow,
   input logic              rsp_string_done
);

   // No result survives reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_window_length)
         && $stable(rsp_best_length) && $stable(rsp_overflow)
         && $stable(rsp_string_done))
      else $error("stalled result changed");

   // The current window never beats the best of its string.
   a_win_le_best: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_length <= rsp_best_length)
      else $error("window longer than best");

   // A counted byte always lies in a window of at least itself, and the best length never exceeds MAX_LEN.
   a_win_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow |-> rsp_window_length != '0
         && rsp_best_length <= LEN_W'(MAX_LEN))
      else $error("window length out of range");

endmodule

bind longest_unique_run_tracker lurt_checker u_lurt_checker (.*);
